### rtl/core/e2c_pkg.sv
// ============================================================================
// e2c_pkg: shared types, microcode formats and calendar tables
// Control word layout, datapath action codes, divisor table and
// leap-year / month-length helpers for the epoch to calendar unit.
// ============================================================================
package e2c_pkg;

    localparam int InW    = 32;
    localparam int OutW   = 48;
    localparam int PcW    = 4;
    localparam int RemW   = 17;
    localparam int DaysW  = 16;

    typedef logic [PcW-1:0]  pc_t;

    // microprogram addresses
    localparam pc_t S_WAIT      = 4'd0;
    localparam pc_t S_DIV_DAY   = 4'd1;
    localparam pc_t S_SAVE_DAYS = 4'd2;
    localparam pc_t S_DIV_HOUR  = 4'd3;
    localparam pc_t S_SAVE_HOUR = 4'd4;
    localparam pc_t S_DIV_MIN   = 4'd5;
    localparam pc_t S_SAVE_MIN  = 4'd6;
    localparam pc_t S_DIV_WEEK  = 4'd7;
    localparam pc_t S_SAVE_WDAY = 4'd8;
    localparam pc_t S_YEAR      = 4'd9;
    localparam pc_t S_MON_INIT  = 4'd10;
    localparam pc_t S_MON       = 4'd11;
    localparam pc_t S_EMIT      = 4'd12;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_LOOP_YEAR,
        C_LOOP_MON,
        C_WAIT_OUT
    } cond_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_DIV,
        A_SAVE_DAYS,
        A_SAVE_HOUR,
        A_SAVE_MIN,
        A_SAVE_WDAY,
        A_YEAR,
        A_MON_INIT,
        A_MON,
        A_EMIT
    } act_t;

    typedef enum logic [1:0] {
        D_DAY,
        D_HOUR,
        D_MIN,
        D_WEEK
    } dsel_t;

    typedef struct packed {
        cond_t cond;
        act_t  act;
        dsel_t dsel;
        pc_t   nxt;
    } uword_t;

    typedef struct packed {
        act_t  act;
        dsel_t dsel;
        logic  fire;
    } ctrl_t;

    typedef struct packed {
        logic year_more;
        logic mon_more;
    } stat_t;

    typedef struct packed {
        logic [5:0] sec_of_minute;
        logic [5:0] min_of_hour;
        logic [4:0] hour_24;
        logic [3:0] hour_12;
        logic       is_pm;
        logic [2:0] week_day;
        logic [4:0] month_day;
        logic [3:0] month_num;
        logic [7:0] year_offset;
    } res_t;

    function automatic logic [RemW-1:0] divisor(input dsel_t sel);
        logic [RemW-1:0] d;
        case (sel)
            D_DAY:   d = 17'd86400;
            D_HOUR:  d = 17'd3600;
            D_MIN:   d = 17'd60;
            D_WEEK:  d = 17'd7;
            default: d = 17'd7;
        endcase
        return d;
    endfunction

    // gregorian rule over 1970..2225: centuries 2100 and 2200 are common
    function automatic logic is_leap(input logic [7:0] yoff);
        logic [11:0] y;
        y = 12'd1970 + {4'd0, yoff};
        return (y[1:0] == 2'd0) && (y != 12'd2100) && (y != 12'd2200);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] yoff);
        return is_leap(yoff) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/epoch_to_calendar_unit.sv
// ============================================================================
// epoch_to_calendar_unit: seconds-since-1970 to calendar date and time
// Top level: sequencer, datapath and output beat register.
// ============================================================================
// usage
//   s_axis carries one 32-bit count of seconds since 1970-01-01 00:00:00
//   per beat; m_axis returns one beat per input with second, minute,
//   24-hour and 12-hour hour, pm flag, weekday (sunday = 1), day of
//   month, month (january = 1) and year offset from 1970
//   one input is converted at a time; s_axis_tready is high only while
//   the sequencer waits for a new beat
//   the four divisions run through the shared reciprocal multiplier, then
//   the year stepping loop subtracts one year length per cycle for Y
//   (0..136) years of offset and the month loop steps M (0..11) months
//   with a free receiver a new beat is taken in the cycle after each
//   result is emitted
//   if the receiver stalls, the next conversion finishes and then holds
//   until the output register is free
//   reset clears the sequencer and the output valid flag
// ============================================================================
module epoch_to_calendar_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [e2c_pkg::InW-1:0]  s_axis_tdata,   // epoch_seconds
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // sec_of_minute, min_of_hour, hour_24, hour_12, is_pm, week_day,
    // month_day, month_num, year_offset, zero fill
    output logic [e2c_pkg::OutW-1:0] m_axis_tdata
);
    import e2c_pkg::*;

    ctrl_t          ctrl;
    stat_t          stat;
    res_t           res;
    logic           out_free;
    logic           emit_fire;
    logic           m_valid_reg, m_valid_next;
    logic [OutW-1:0] m_data_reg;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign emit_fire = (ctrl.act == A_EMIT) && ctrl.fire;

    e2c_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_axis_tready)
    );

    e2c_dpath u_dpath (
        .clk           (clk),
        .ctrl          (ctrl),
        .epoch_seconds (s_axis_tdata),
        .stat          (stat),
        .res           (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (emit_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            m_data_reg <= {6'd0, res.year_offset, res.month_num, res.month_day,
                           res.week_day, res.is_pm, res.hour_12, res.hour_24,
                           res.min_of_hour, res.sec_of_minute};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // an accepted beat moves the sequencer off its wait step
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after an accepted beat");

    // a finished conversion never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !emit_fire)
        else $error("result register overwritten while stalled");

    // emitted beat is presented with a sane date
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (m_axis_tvalid && (m_axis_tdata[41:34] <= 8'd136)
                       && (m_axis_tdata[29:25] != 5'd0)
                       && (m_axis_tdata[33:30] != 4'd0)))
        else $error("emitted date out of range");

endmodule

### rtl/core/e2c_seq.sv
// ============================================================================
// e2c_seq: microcode sequencer
// Program counter and control store; issues one control word per cycle
// and takes conditional jumps on handshake and loop status.
// ============================================================================
module e2c_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_free,
    input  e2c_pkg::stat_t stat,
    output e2c_pkg::ctrl_t ctrl,
    output logic          in_ready
);
    import e2c_pkg::*;

    pc_t    pc_reg, pc_next;
    uword_t uw;
    logic   adv;

    function automatic uword_t rom(input pc_t pc);
        uword_t w;
        case (pc)
            S_WAIT:      w = '{C_WAIT_IN,   A_LOAD,      D_DAY,  S_DIV_DAY};
            S_DIV_DAY:   w = '{C_NEXT,      A_DIV,       D_DAY,  S_SAVE_DAYS};
            S_SAVE_DAYS: w = '{C_NEXT,      A_SAVE_DAYS, D_DAY,  S_DIV_HOUR};
            S_DIV_HOUR:  w = '{C_NEXT,      A_DIV,       D_HOUR, S_SAVE_HOUR};
            S_SAVE_HOUR: w = '{C_NEXT,      A_SAVE_HOUR, D_HOUR, S_DIV_MIN};
            S_DIV_MIN:   w = '{C_NEXT,      A_DIV,       D_MIN,  S_SAVE_MIN};
            S_SAVE_MIN:  w = '{C_NEXT,      A_SAVE_MIN,  D_MIN,  S_DIV_WEEK};
            S_DIV_WEEK:  w = '{C_NEXT,      A_DIV,       D_WEEK, S_SAVE_WDAY};
            S_SAVE_WDAY: w = '{C_NEXT,      A_SAVE_WDAY, D_WEEK, S_YEAR};
            S_YEAR:      w = '{C_LOOP_YEAR, A_YEAR,      D_DAY,  S_MON_INIT};
            S_MON_INIT:  w = '{C_NEXT,      A_MON_INIT,  D_DAY,  S_MON};
            S_MON:       w = '{C_LOOP_MON,  A_MON,       D_DAY,  S_EMIT};
            S_EMIT:      w = '{C_WAIT_OUT,  A_EMIT,      D_DAY,  S_WAIT};
            default:     w = '{C_NEXT,      A_NONE,      D_DAY,  S_WAIT};
        endcase
        return w;
    endfunction

    assign uw = rom(pc_reg);

    always_comb
    begin
        adv       = 1'b1;
        ctrl.act  = uw.act;
        ctrl.dsel = uw.dsel;
        ctrl.fire = 1'b1;
        case (uw.cond)
            C_NEXT:
            begin
                adv       = 1'b1;
                ctrl.fire = 1'b1;
            end
            C_WAIT_IN:
            begin
                adv       = in_valid;
                ctrl.fire = in_valid;
            end
            C_LOOP_YEAR: adv = !stat.year_more;
            C_LOOP_MON:  adv = !stat.mon_more;
            C_WAIT_OUT:
            begin
                adv       = out_free;
                ctrl.fire = out_free;
            end
            default:
            begin
                adv       = 1'b1;
                ctrl.fire = 1'b0;
            end
        endcase
    end

    assign in_ready  = (uw.cond == C_WAIT_IN);

    always_comb
    begin
        pc_next = adv ? uw.nxt : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/core/e2c_dpath.sv
// ============================================================================
// e2c_dpath: conversion datapath
// Shared reciprocal-multiply divider by a selected constant, day counter
// with year and month subtraction, and the time-of-day result registers.
// ============================================================================
module e2c_dpath (
    input  logic                      clk,
    input  e2c_pkg::ctrl_t            ctrl,
    input  logic [e2c_pkg::InW-1:0]   epoch_seconds,
    output e2c_pkg::stat_t            stat,
    output e2c_pkg::res_t             res
);
    import e2c_pkg::*;

    logic [InW-1:0]        num_reg;
    logic [DaysW-1:0]      quo_reg;
    logic [DaysW-1:0]      days_reg;
    logic [4:0]            hour_reg;
    logic [5:0]            min_reg;
    logic [5:0]            sec_reg;
    logic [2:0]            wday_reg;
    logic [7:0]            year_reg;
    logic [3:0]            mon_reg;

    logic [24:0]           mul_a;
    logic [25:0]           mul_b;
    logic [50:0]           prod;
    logic [DaysW-1:0]      quo;
    logic [RemW-1:0]       dvs;
    logic [DaysW+RemW-1:0] quo_dvs;
    logic [RemW-1:0]       rem;
    logic [8:0]            ylen;
    logic [4:0]            mlen;
    logic [DaysW-1:0]      days_wk;

    // quotient as (x >> s) * ceil(2^k / (d >> s)) >> k, exact over each range
    always_comb
    begin
        case (ctrl.dsel)
            D_DAY:
            begin
                mul_a = num_reg[31:7];
                mul_b = 26'd50903317;
            end
            D_HOUR:
            begin
                mul_a = {12'd0, num_reg[16:4]};
                mul_b = 26'd9321;
            end
            D_MIN:
            begin
                mul_a = {15'd0, num_reg[11:2]};
                mul_b = 26'd1093;
            end
            D_WEEK:
            begin
                mul_a = {9'd0, num_reg[15:0]};
                mul_b = 26'd74899;
            end
            default:
            begin
                mul_a = {9'd0, num_reg[15:0]};
                mul_b = 26'd74899;
            end
        endcase
    end

    assign prod = {26'd0, mul_a} * {25'd0, mul_b};

    always_comb
    begin
        case (ctrl.dsel)
            D_DAY:   quo = prod[50:35];
            D_HOUR:  quo = prod[36:21];
            D_MIN:   quo = prod[29:14];
            D_WEEK:  quo = prod[34:19];
            default: quo = prod[34:19];
        endcase
    end

    assign dvs     = divisor(ctrl.dsel);
    assign quo_dvs = {{RemW{1'b0}}, quo_reg} * {{DaysW{1'b0}}, dvs};
    assign rem     = num_reg[RemW-1:0] - quo_dvs[RemW-1:0];
    assign ylen    = year_len(year_reg);
    assign mlen    = month_len(mon_reg, is_leap(year_reg));
    assign days_wk = days_reg + DaysW'(4);

    assign stat.year_more = (days_reg >= {7'd0, ylen});
    assign stat.mon_more  = (days_reg >= {11'd0, mlen}) && (mon_reg != 4'd11);

    always_ff @(posedge clk)
    begin
        case (ctrl.act)
            A_LOAD:
            begin
                if (ctrl.fire)
                begin
                    num_reg <= epoch_seconds;
                end
            end
            A_DIV:
            begin
                quo_reg <= quo;
            end
            A_SAVE_DAYS:
            begin
                days_reg <= quo_reg;
                num_reg  <= {15'd0, rem};
            end
            A_SAVE_HOUR:
            begin
                hour_reg <= quo_reg[4:0];
                num_reg  <= {15'd0, rem};
            end
            A_SAVE_MIN:
            begin
                min_reg <= quo_reg[5:0];
                sec_reg <= rem[5:0];
                num_reg <= {16'd0, days_wk};
            end
            A_SAVE_WDAY:
            begin
                wday_reg <= rem[2:0] + 3'd1;
                year_reg <= '0;
            end
            A_YEAR:
            begin
                if (stat.year_more)
                begin
                    days_reg <= days_reg - {7'd0, ylen};
                    year_reg <= year_reg + 8'd1;
                end
            end
            A_MON_INIT:
            begin
                mon_reg <= '0;
            end
            A_MON:
            begin
                if (stat.mon_more)
                begin
                    days_reg <= days_reg - {11'd0, mlen};
                    mon_reg  <= mon_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.sec_of_minute = sec_reg;
        res.min_of_hour   = min_reg;
        res.hour_24       = hour_reg;
        res.is_pm         = (hour_reg >= 5'd12);
        if (hour_reg == 5'd0)
        begin
            res.hour_12 = 4'd12;
        end
        else if (hour_reg > 5'd12)
        begin
            res.hour_12 = 4'(hour_reg - 5'd12);
        end
        else
        begin
            res.hour_12 = hour_reg[3:0];
        end
        res.week_day    = wday_reg;
        res.month_day   = days_reg[4:0] + 5'd1;
        res.month_num   = mon_reg + 4'd1;
        res.year_offset = year_reg;
    end

endmodule
